FILE: src/cic_pkg.sv
package cic_pkg;

  localparam int SLOT_W          = 6;
  localparam int ID_W            = 16;
  localparam int FLEN_W          = 7;
  localparam logic [FLEN_W-1:0] FLEN_RST = 7'd64;
  localparam int DEF_MAX_SLOTS   = 64;
  localparam int DEF_MAX_PACKETS = 32;

  typedef enum logic {
    REQ_ADD = 1'b0,
    REQ_EOF = 1'b1
  } req_e;

  // request word as classified by the front end
  typedef struct packed {
    req_e              req;
    logic [ID_W-1:0]   id;
    logic [SLOT_W-1:0] sa;
    logic [SLOT_W-1:0] sb;
    logic              slot_ok;
  } cmd_t;

  // result word
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
    logic            ovf;
    logic            last;
  } res_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_RD_A,
    ST_WR_A,
    ST_RD_B,
    ST_WR_B,
    ST_SRD,
    ST_SCHK,
    ST_TB,
    ST_FIN
  } eng_e;

endpackage

FILE: src/cic_fifo.sv
module cic_fifo import cic_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_en_i,
  input  logic [W-1:0] wr_data_i,
  output logic         full_o,
  input  logic         rd_en_i,
  output logic [W-1:0] rd_data_o,
  output logic         empty_o
);

  logic [W-1:0] mem_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;
  logic         do_wr, do_rd;

  assign full_o    = (cnt_q == 2'd2);
  assign empty_o   = (cnt_q == 2'd0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_wr) wp_q <= !wp_q;
      if (do_rd) rp_q <= !rp_q;
      if (do_wr && !do_rd) cnt_q <= cnt_q + 2'd1;
      else if (do_rd && !do_wr) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

FILE: src/cic_front.sv
module cic_front import cic_pkg::*; #(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic              req_type_i,
  input  logic [ID_W-1:0]   packet_id_i,
  input  logic [SLOT_W-1:0] slot_a_i,
  input  logic [SLOT_W-1:0] slot_b_i,
  output cmd_t              cmd_o,
  output logic              cmd_valid_o,
  input  logic              cmd_pop_i
);

  cmd_t cmd_in;
  logic cmd_empty;

  // slots outside the store make the add a no-op
  always_comb begin
    cmd_in.req     = req_e'(req_type_i);
    cmd_in.id      = packet_id_i;
    cmd_in.sa      = slot_a_i;
    cmd_in.sb      = slot_b_i;
    cmd_in.slot_ok = (32'(slot_a_i) < MAX_SLOTS) && (32'(slot_b_i) < MAX_SLOTS);
  end

  cic_fifo #(.W($bits(cmd_t))) u_cmdq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push),
    .wr_data_i (cmd_in),
    .full_o    (full),
    .rd_en_i   (cmd_pop_i),
    .rd_data_o (cmd_o),
    .empty_o   (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

FILE: src/cic_back.sv
module cic_back import cic_pkg::*; #(
  parameter int MAX_SLOTS   = DEF_MAX_SLOTS,
  parameter int MAX_PACKETS = DEF_MAX_PACKETS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [FLEN_W-1:0] frame_len_i,
  input  cmd_t              cmd_i,
  input  logic              cmd_valid_i,
  output logic              cmd_pop_o,
  output res_t              res_o,
  output logic              res_push_o,
  input  logic              res_full_i
);

  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int KW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
  localparam int CW = $clog2(2 * MAX_PACKETS + 1);
  localparam int FW = $clog2(MAX_PACKETS + 1);
  localparam int LW = (SW + 1 > FLEN_W) ? SW + 1 : FLEN_W;
  localparam int EW = CW + KW;
  localparam int TW = ID_W + 2 * SW;

  // slot store: replica count and xor of owning entry indexes
  logic [EW-1:0] smem [MAX_SLOTS];
  logic [EW-1:0] srd_q;
  logic [SW-1:0] s_raddr, s_waddr;
  logic [EW-1:0] s_wdata;
  logic          s_we;

  // packet table: id and both slots
  logic [TW-1:0] tmem [MAX_PACKETS];
  logic [TW-1:0] tb_q;
  logic [KW-1:0] t_raddr, t_waddr;
  logic [TW-1:0] t_wdata;
  logic          t_we;

  eng_e            state_q, state_d;
  logic [SW-1:0]   idx_q, idx_d;
  logic [SW-1:0]   sa_q, sa_d, sb_q, sb_d;
  logic [KW-1:0]   own_q, own_d;
  logic [FW-1:0]   fill_q, fill_d;
  logic            any_q, any_d;
  logic            ovf_q, ovf_d;
  logic            rem_q, rem_d;
  logic            pend_v_q, pend_v_d;
  logic [ID_W-1:0] pend_id_q, pend_id_d;
  logic            adv;

  logic [CW-1:0]   srd_cnt, upd_cnt;
  logic [KW-1:0]   srd_own;
  logic [LW-1:0]   limit, idx_nxt, fl_ext;

  assign srd_cnt = srd_q[EW-1:KW];
  assign srd_own = srd_q[KW-1:0];
  assign fl_ext  = LW'(frame_len_i);
  assign limit   = (fl_ext > LW'(MAX_SLOTS)) ? LW'(MAX_SLOTS) : fl_ext;
  assign idx_nxt = LW'(idx_q) + LW'(1);

  always_comb begin
    if (!rem_q) upd_cnt = srd_cnt + CW'(1);
    else if (srd_cnt != '0) upd_cnt = srd_cnt - CW'(1);
    else upd_cnt = srd_cnt;
  end

  always_ff @(posedge clk_i) begin
    srd_q <= smem[s_raddr];
    if (s_we) smem[s_waddr] <= s_wdata;
    tb_q <= tmem[t_raddr];
    if (t_we) tmem[t_waddr] <= t_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLR;
      idx_q    <= '0;
      fill_q   <= '0;
      any_q    <= 1'b0;
      ovf_q    <= 1'b0;
      rem_q    <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      fill_q   <= fill_d;
      any_q    <= any_d;
      ovf_q    <= ovf_d;
      rem_q    <= rem_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sa_q      <= sa_d;
    sb_q      <= sb_d;
    own_q     <= own_d;
    pend_id_q <= pend_id_d;
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    sa_d       = sa_q;
    sb_d       = sb_q;
    own_d      = own_q;
    fill_d     = fill_q;
    any_d      = any_q;
    ovf_d      = ovf_q;
    rem_d      = rem_q;
    pend_v_d   = pend_v_q;
    pend_id_d  = pend_id_q;
    adv        = 1'b0;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    s_raddr    = idx_q;
    s_we       = 1'b0;
    s_waddr    = idx_q;
    s_wdata    = '0;
    t_raddr    = own_q;
    t_we       = 1'b0;
    t_waddr    = fill_q[KW-1:0];
    t_wdata    = {cmd_i.id, SW'(cmd_i.sa), SW'(cmd_i.sb)};

    case (state_q)
      ST_CLR: begin
        s_we     = 1'b1;
        fill_d   = '0;
        ovf_d    = 1'b0;
        pend_v_d = 1'b0;
        if (idx_q == SW'(MAX_SLOTS - 1)) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + SW'(1);
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.req == REQ_ADD) begin
            if (!cmd_i.slot_ok) begin
              state_d = ST_IDLE;
            end else if (fill_q == FW'(MAX_PACKETS)) begin
              ovf_d = 1'b1;
            end else begin
              t_we    = 1'b1;
              own_d   = fill_q[KW-1:0];
              sa_d    = SW'(cmd_i.sa);
              sb_d    = SW'(cmd_i.sb);
              rem_d   = 1'b0;
              state_d = ST_RD_A;
            end
          end else begin
            idx_d = '0;
            any_d = 1'b0;
            if (fill_q == '0 || limit == '0) state_d = ST_FIN;
            else state_d = ST_SRD;
          end
        end
      end
      ST_RD_A: begin
        s_raddr = sa_q;
        state_d = ST_WR_A;
      end
      ST_WR_A: begin
        s_we    = 1'b1;
        s_waddr = sa_q;
        s_wdata = {upd_cnt, srd_own ^ own_q};
        state_d = ST_RD_B;
      end
      ST_RD_B: begin
        s_raddr = sb_q;
        state_d = ST_WR_B;
      end
      ST_WR_B: begin
        s_we    = 1'b1;
        s_waddr = sb_q;
        s_wdata = {upd_cnt, srd_own ^ own_q};
        if (rem_q) begin
          fill_d = fill_q - FW'(1);
          any_d  = 1'b1;
          adv    = 1'b1;
        end else begin
          fill_d  = fill_q + FW'(1);
          state_d = ST_IDLE;
        end
      end
      ST_SRD: begin
        state_d = ST_SCHK;
      end
      ST_SCHK: begin
        if (srd_cnt == CW'(1)) begin
          t_raddr = srd_own;
          own_d   = srd_own;
          state_d = ST_TB;
        end else begin
          adv = 1'b1;
        end
      end
      ST_TB: begin
        // the previous resolved packet goes out once we know it is not the last
        if (!(pend_v_q && res_full_i)) begin
          if (pend_v_q) begin
            res_push_o = 1'b1;
            res_o      = '{valid: 1'b1, id: pend_id_q, ovf: ovf_q, last: 1'b0};
          end
          pend_v_d  = 1'b1;
          pend_id_d = tb_q[TW-1:2*SW];
          sa_d      = tb_q[2*SW-1:SW];
          sb_d      = tb_q[SW-1:0];
          rem_d     = 1'b1;
          state_d   = ST_RD_A;
        end
      end
      ST_FIN: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          res_o      = '{valid: pend_v_q, id: pend_v_q ? pend_id_q : '0,
                         ovf: ovf_q, last: 1'b1};
          idx_d      = '0;
          state_d    = ST_CLR;
        end
      end
      default: begin
        state_d = ST_CLR;
        idx_d   = '0;
      end
    endcase

    // step to the next slot, or start another pass, or finish
    if (adv) begin
      if (idx_nxt == limit) begin
        idx_d = '0;
        if (any_d && fill_d != '0) begin
          any_d   = 1'b0;
          state_d = ST_SRD;
        end else begin
          state_d = ST_FIN;
        end
      end else begin
        idx_d   = idx_nxt[SW-1:0];
        state_d = ST_SRD;
      end
    end
  end

endmodule

FILE: src/crdsa_interference_cancel.sv
// Successive interference cancellation for one CRDSA frame. Add words (req_type 0) store a
// packet id with the two slots that carry its replicas and give no result; an add whose slot
// lies outside the store is dropped, and one that finds the table full is dropped and
// flagged. An end-of-frame word (req_type 1) sweeps slots 0 to frame_length-1 (capped at
// MAX_SLOTS) again and again; every slot holding exactly one replica yields that packet's id,
// and both of its replicas are taken out at once. The run gives one result word per resolved
// packet, in resolution order, with last_of_run on the final one, or a single word with
// resolved_valid low when nothing resolves; overflow_seen reports adds dropped because the
// table was full. The store is then cleared. In the engine an add reads and then writes the
// slot store for each of its two slots. A run takes the word, visits the slots in turn,
// removes each resolved packet the same way an add stores it, and makes at most one pass
// more than packets resolved; it then posts the last word (waiting while the result queue
// is full) and makes a clearing pass over the slot memory, which also runs after reset. The
// slot memory has one read and one write port, and every replica update is a read followed
// by a write. A two-word queue on each side lets the sender and receiver run ahead of or behind the engine.
module crdsa_interference_cancel import cic_pkg::*; #(
  parameter int MAX_SLOTS   = DEF_MAX_SLOTS,
  parameter int MAX_PACKETS = DEF_MAX_PACKETS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [FLEN_W-1:0] cfg_wdata_i,
  // request side
  input  logic              push,
  output logic              full,
  input  logic              req_type_i,
  input  logic [ID_W-1:0]   packet_id_i,
  input  logic [SLOT_W-1:0] slot_a_i,
  input  logic [SLOT_W-1:0] slot_b_i,
  // result side
  output logic              empty,
  input  logic              pop,
  output logic              resolved_valid_o,
  output logic [ID_W-1:0]   resolved_id_o,
  output logic              overflow_seen_o,
  output logic              last_of_run_o
);

  logic [FLEN_W-1:0] frame_len_q;
  cmd_t              cmd;
  logic              cmd_valid, cmd_pop;
  res_t              res_in, res_out;
  logic              res_push, res_full;

  // frame length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_q <= FLEN_RST;
    end else if (cfg_we_i) begin
      frame_len_q <= cfg_wdata_i;
    end
  end

  // front end: takes request words and checks slot range
  cic_front #(.MAX_SLOTS(MAX_SLOTS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_type_i  (req_type_i),
    .packet_id_i (packet_id_i),
    .slot_a_i    (slot_a_i),
    .slot_b_i    (slot_b_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  // engine: store, peeling sweeps and clearing
  cic_back #(.MAX_SLOTS(MAX_SLOTS), .MAX_PACKETS(MAX_PACKETS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frame_len_i (frame_len_q),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // result queue decouples the engine from the receiver
  cic_fifo #(.W($bits(res_t))) u_resq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (res_push),
    .wr_data_i (res_in),
    .full_o    (res_full),
    .rd_en_i   (pop),
    .rd_data_o (res_out),
    .empty_o   (empty)
  );

  assign resolved_valid_o = res_out.valid;
  assign resolved_id_o    = res_out.id;
  assign overflow_seen_o  = res_out.ovf;
  assign last_of_run_o    = res_out.last;

endmodule

FILE: src/cic_checker.sv
module cic_assertions import cic_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            empty,
  input logic            pop,
  input logic            resolved_valid_o,
  input logic [ID_W-1:0] resolved_id_o,
  input logic            last_of_run_o
);

  // an empty run is always closed by its only word
  a_none_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !resolved_valid_o) |-> last_of_run_o)
    else $error("unresolved word not marked last");

  a_none_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !resolved_valid_o) |-> (resolved_id_o == '0))
    else $error("unresolved word carries an id");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(resolved_id_o) && $stable(last_of_run_o)))
    else $error("waiting result changed");

endmodule

bind crdsa_interference_cancel cic_assertions u_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .empty            (empty),
  .pop              (pop),
  .resolved_valid_o (resolved_valid_o),
  .resolved_id_o    (resolved_id_o),
  .last_of_run_o    (last_of_run_o)
);

FILE: sim/cic_checker.sv
`timescale 1ns / 1ps

module cic_checker import cic_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [FLEN_W-1:0] cfg_wdata_i,
  input  logic              push,
  input  logic              full,
  input  logic              req_type_i,
  input  logic [ID_W-1:0]   packet_id_i,
  input  logic [SLOT_W-1:0] slot_a_i,
  input  logic [SLOT_W-1:0] slot_b_i,
  input  logic              empty,
  input  logic              pop,
  input  logic              resolved_valid_o,
  input  logic [ID_W-1:0]   resolved_id_o,
  input  logic              overflow_seen_o,
  input  logic              last_of_run_o,
  output int                fail_count,
  output int                pending,
  output int                words_seen,
  output int                runs_seen
);

  localparam int NSLOT = DEF_MAX_SLOTS;
  localparam int NPKT  = DEF_MAX_PACKETS;

  typedef logic bool_t;

  logic              pkt_live [NPKT];
  logic [ID_W-1:0]   pkt_id   [NPKT];
  logic [SLOT_W-1:0] pkt_sa   [NPKT];
  logic [SLOT_W-1:0] pkt_sb   [NPKT];
  int                occupancy [NSLOT];
  int                stored;
  logic              dropped;
  logic [FLEN_W-1:0] flen;
  res_t              resolved_q[$];

  function automatic void wipe_frame();
    for (int k = 0; k < NPKT; k++) pkt_live[k] = 1'b0;
    for (int s = 0; s < NSLOT; s++) occupancy[s] = 0;
    stored  = 0;
    dropped = 1'b0;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // peel the frame, queueing one word per resolved packet, or a single unresolved word when none resolves
  function automatic void peel_frame();
    int   lim, owner, n;
    bool_t any;
    res_t w;
    lim = (flen < NSLOT) ? flen : NSLOT;
    n = 0;
    while (stored > 0) begin
      any = 1'b0;
      for (int s = 0; s < lim; s++) begin
        if (occupancy[s] != 1) continue;
        owner = -1;
        for (int k = 0; k < NPKT; k++)
          if (owner < 0 && pkt_live[k] && (pkt_sa[k] == s || pkt_sb[k] == s)) owner = k;
        if (owner < 0) continue;
        any = 1'b1;
        w.valid = 1'b1; w.id = pkt_id[owner]; w.ovf = dropped; w.last = 1'b0;
        resolved_q.insert(resolved_q.size(), w);
        n++;
        if (occupancy[pkt_sa[owner]] > 0) occupancy[pkt_sa[owner]]--;
        if (occupancy[pkt_sb[owner]] > 0) occupancy[pkt_sb[owner]]--;
        pkt_live[owner] = 1'b0;
        stored--;
      end
      if (!any) break;
    end
    if (n == 0) begin
      w.valid = 1'b0; w.id = '0; w.ovf = dropped; w.last = 1'b1;
      resolved_q.insert(resolved_q.size(), w);
    end else begin
      resolved_q[$].last = 1'b1;
    end
    wipe_frame();
  endfunction

  initial begin
    fail_count = 0;
    words_seen = 0;
    runs_seen  = 0;
    pending    = 0;
    flen       = FLEN_RST;
    wipe_frame();
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (cfg_we_i) flen = cfg_wdata_i;
      if (push && !full) begin
        if (req_type_i == REQ_ADD) begin
          if (stored >= NPKT) begin
            dropped = 1'b1;
          end else begin
            for (int k = 0; k < NPKT; k++)
              if (!pkt_live[k]) begin
                pkt_live[k] = 1'b1; pkt_id[k] = packet_id_i;
                pkt_sa[k] = slot_a_i; pkt_sb[k] = slot_b_i;
                occupancy[slot_a_i]++; occupancy[slot_b_i]++;
                stored++;
                break;
              end
          end
        end else begin
          peel_frame();
          runs_seen++;
        end
      end
      if (pop && !empty) begin
        words_seen++;
        if (resolved_q.size() == 0) begin
          report("unexpected word", 32'(resolved_id_o), 32'd0);
        end else begin
          want = resolved_q.pop_front();
          if (resolved_valid_o !== want.valid)
            report("resolved_valid", 32'(resolved_valid_o), 32'(want.valid));
          if (resolved_id_o !== want.id)
            report("resolved_id", 32'(resolved_id_o), 32'(want.id));
          if (overflow_seen_o !== want.ovf)
            report("overflow_seen", 32'(overflow_seen_o), 32'(want.ovf));
          if (last_of_run_o !== want.last)
            report("last_of_run", 32'(last_of_run_o), 32'(want.last));
        end
      end
      pending = resolved_q.size();
    end
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cic_pkg::*;

  logic              clk_i, rst_ni;
  logic              cfg_we_i;
  logic [FLEN_W-1:0] cfg_wdata_i;
  logic              push, full;
  logic              req_type_i;
  logic [ID_W-1:0]   packet_id_i;
  logic [SLOT_W-1:0] slot_a_i, slot_b_i;
  logic              empty, pop;
  logic              resolved_valid_o, overflow_seen_o, last_of_run_o;
  logic [ID_W-1:0]   resolved_id_o;
  int                fail_count, pending, words_seen, runs_seen;

  // sender and receiver idling controls
  bit idle_on;
  bit hold_rx;
  int long_hold;

  int sent;
  logic [FLEN_W-1:0] sent_lengths [5] = '{7'd64, 7'd16, 7'd2, 7'd100, 7'd33};

  crdsa_interference_cancel dut (.*);
  cic_checker chk (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // long fixed limit, far longer than any run
  initial begin
    #20ms;
    $display("FAIL crdsa_interference_cancel");
    $finish;
  end

  // receiver: random stall bursts, plus one long hold requested by the sender
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold > 0) begin
        pop = 1'b0;
        long_hold--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        pop = 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk_i);
      end else begin
        pop = 1'b1;
      end
    end
  end

  // drive one word and hold it until the block takes it
  task automatic send_word(input req_e kind, input logic [ID_W-1:0] id,
                           input logic [SLOT_W-1:0] sa, input logic [SLOT_W-1:0] sb);
    if (idle_on && $urandom_range(0, 6) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    push = 1'b1; req_type_i = kind; packet_id_i = id; slot_a_i = sa; slot_b_i = sb;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
    push = 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    // the engine clears its slot memory after each run
    repeat (200) @(negedge clk_i);
  endtask

  task automatic set_frame_length(input logic [FLEN_W-1:0] v);
    drain();
    cfg_we_i = 1'b1; cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // a frame of n packets, most with distinct slots so that peeling goes deep
  task automatic random_frame(input int n, input int span);
    logic [SLOT_W-1:0] a, b;
    for (int i = 0; i < n; i++) begin
      a = SLOT_W'($urandom_range(0, span - 1));
      b = ($urandom_range(0, 9) == 0) ? a : SLOT_W'($urandom_range(0, span - 1));
      send_word(REQ_ADD, ID_W'($urandom), a, b);
    end
    send_word(REQ_EOF, ID_W'($urandom), SLOT_W'($urandom), SLOT_W'($urandom));
  endtask

  initial begin
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_wdata_i = '0; push = 1'b0;
    req_type_i = REQ_ADD; packet_id_i = '0; slot_a_i = '0; slot_b_i = '0;
    idle_on = 1'b0; long_hold = 0; sent = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (80) @(negedge clk_i);

    // directed: field extremes, empty frame, same-slot pair, chain of peels
    send_word(REQ_EOF, 16'hffff, 6'h3f, 6'h3f);
    send_word(REQ_ADD, 16'h0000, 6'd0, 6'd0);
    send_word(REQ_ADD, 16'hffff, 6'd63, 6'd63);
    send_word(REQ_ADD, 16'ha5a5, 6'd0, 6'd63);
    send_word(REQ_EOF, 16'h0000, 6'd0, 6'd0);
    send_word(REQ_ADD, 16'h1111, 6'd1, 6'd2);
    send_word(REQ_ADD, 16'h2222, 6'd2, 6'd3);
    send_word(REQ_ADD, 16'h3333, 6'd3, 6'd4);
    send_word(REQ_ADD, 16'h5a5a, 6'd42, 6'd21);
    send_word(REQ_EOF, 16'h0, 6'd0, 6'd0);
    sent = 10;

    // frame length zero and one, replicas beyond the swept range
    set_frame_length(7'd0);
    send_word(REQ_ADD, 16'h0101, 6'd5, 6'd9);
    send_word(REQ_EOF, 16'h0, 6'd0, 6'd0);
    set_frame_length(7'd1);
    send_word(REQ_ADD, 16'h0202, 6'd0, 6'd40);
    send_word(REQ_ADD, 16'h0303, 6'd40, 6'd50);
    send_word(REQ_EOF, 16'h0, 6'd0, 6'd0);
    set_frame_length(7'd127);
    // table overflow: 34 adds into 32 entries
    for (int i = 0; i < 34; i++) send_word(REQ_ADD, ID_W'(16'h4000 + i), 6'(i), 6'(i + 1));
    send_word(REQ_EOF, 16'h0, 6'd0, 6'd0);
    sent += 40;

    // long receiver hold while the sender keeps going, so the input stalls
    long_hold = 400;
    random_frame(3, 8);
    random_frame(3, 8);
    random_frame(3, 8);
    sent += 12;
    drain();

    idle_on = 1'b1;
    foreach (sent_lengths[i]) begin
      set_frame_length(sent_lengths[i]);
      for (int f = 0; f < 5; f++) begin
        int n, span;
        n = $urandom_range(0, 10);
        span = (sent_lengths[i] > 64 || sent_lengths[i] == 0) ? 64 : sent_lengths[i];
        if (span < 2) span = 2;
        random_frame(n, $urandom_range(2, span));
        sent += n + 1;
      end
    end
    // sender pauses until every result is in
    drain();
    idle_on = 1'b0;
    while (sent < 280) begin
      int n;
      n = $urandom_range(0, 12);
      random_frame(n, $urandom_range(2, 64));
      sent += n + 1;
    end

    drain();
    $display("covered %0d words in %0d frames, %0d result words checked",
             sent, runs_seen, words_seen);
    if (fail_count == 0) begin
      $display("PASS crdsa_interference_cancel");
    end else begin
      $display("FAIL crdsa_interference_cancel");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/cic_pkg.sv
src/cic_fifo.sv
src/cic_front.sv
src/cic_back.sv
src/crdsa_interference_cancel.sv
src/cic_checker.sv
sim/cic_checker.sv
sim/testbench.sv
